/* rtl/srfc8_pkg.sv */
// Package for the SPI register-access framer with CRC-8.
// Holds the item structs, the frame and command codes and the CRC byte step.
// No dependencies; imported by spi_register_frame_crc8_unit.
package srfc8_pkg;

  // Item types.
  typedef enum logic {
    OP_START = 1'b0,
    OP_RX    = 1'b1
  } opcode_e;

  // Frame kinds. The unused code is treated as a status frame.
  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_READ   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_WRITE_CODE  = 2'd0,
    CFG_READ_CODE   = 2'd1,
    CFG_STATUS_CODE = 2'd2,
    CFG_ACK_VALUE   = 2'd3
  } cfg_index_e;

  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  localparam logic [7:0] WRITE_CODE_RST  = 8'd242;
  localparam logic [7:0] READ_CODE_RST   = 8'd244;
  localparam logic [7:0] STATUS_CODE_RST = 8'd240;
  localparam logic [7:0] ACK_VALUE_RST   = 8'd165;

  // Frame lengths in bytes, and positions of the CRC and last byte.
  localparam logic [3:0] LEN_LONG      = 4'd8;
  localparam logic [3:0] LEN_SHORT     = 4'd4;
  localparam logic [2:0] CRC_POS_LONG  = 3'd6;
  localparam logic [2:0] CRC_POS_SHORT = 3'd2;
  localparam logic [2:0] LAST_LONG     = 3'd7;
  localparam logic [2:0] LAST_SHORT    = 3'd3;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  op_kind;
    logic [6:0]  reg_address;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        is_reply;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [10:0] status_bits;
    logic [31:0] read_data;
    logic [7:0]  crc_byte;
    logic [7:0]  ack_byte;
    logic        nack;
  } out_item_t;

  // One byte of CRC-8, MSB first, polynomial 0x07.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if ((c & CRC_TOP) != 8'd0) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/spi_register_frame_crc8_unit.sv */
// SPI register-access framer with CRC-8: builds transmit frames and parses replies.
// Depends on srfc8_pkg for item structs, codes and the CRC byte step.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o  | in_data_i (in_item_t)
//   out     | output    | out_valid_o/out_stall_i| out_data_o (out_item_t)
//   cfg     | input     | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// An item waits in the input register, then is handled in one pass into the output
// register. A start request occupies the frame emitter for a frame of 4 or 8 bytes,
// one transmit byte per cycle while the output is not stalled. The emitter sets the rate.
// Reset is asynchronous and active low; it clears control state and loads register
// defaults. A stalled output holds its item and the emitter; input stalls behind it.
module spi_register_frame_crc8_unit
  import srfc8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i
);

  // Configuration registers.
  logic [7:0] write_code_q, read_code_q, status_code_q, ack_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      write_code_q  <= WRITE_CODE_RST;
      read_code_q   <= READ_CODE_RST;
      status_code_q <= STATUS_CODE_RST;
      ack_value_q   <= ACK_VALUE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WRITE_CODE:  write_code_q  <= cfg_wdata_i;
        CFG_READ_CODE:   read_code_q   <= cfg_wdata_i;
        CFG_STATUS_CODE: status_code_q <= cfg_wdata_i;
        CFG_ACK_VALUE:   ack_value_q   <= cfg_wdata_i;
        default:         ;
      endcase
    end
  end

  // Input register, output register, emitter and receive state.
  in_item_t        in_q;
  logic            in_vld_q, in_vld_d;
  out_item_t       out_q, out_d;
  logic            out_vld_q, out_vld_d;
  logic            em_active_q, em_active_d;
  logic [2:0]      em_idx_q, em_idx_d;
  logic [2:0]      em_last_q, em_last_d;
  logic [2:0]      em_crcpos_q, em_crcpos_d;
  logic [7:0]      em_crc_q, em_crc_d;
  logic [7:0][7:0] em_buf_q, em_buf_d;
  kind_e           frame_kind_q, frame_kind_d;
  logic [3:0]      rx_count_q, rx_count_d;
  logic [7:0][7:0] rx_frame_q, rx_frame_d;

  logic out_free, consume, in_accept;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign consume    = out_free && !em_active_q && in_vld_q;
  assign in_stall_o = in_vld_q && !consume;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_accept || (in_vld_q && !consume);

  // Working values for the item in the input register.
  kind_e           kind;
  logic [7:0]      cmd_byte;
  logic [7:0]      em_byte;
  logic [3:0]      rx_len;
  logic [7:0][7:0] rx_new;
  logic [7:0]      reply_ack;

  always_comb begin
    case (in_q.op_kind)
      KIND_WRITE: begin
        kind     = KIND_WRITE;
        cmd_byte = write_code_q;
      end
      KIND_READ: begin
        kind     = KIND_READ;
        cmd_byte = read_code_q;
      end
      default: begin
        kind     = KIND_STATUS;
        cmd_byte = status_code_q;
      end
    endcase
  end

  assign em_byte = (em_idx_q == em_crcpos_q) ? em_crc_q : em_buf_q[em_idx_q];
  assign rx_len  = (frame_kind_q == KIND_STATUS) ? LEN_SHORT : LEN_LONG;

  always_comb begin
    rx_new                   = rx_frame_q;
    rx_new[rx_count_q[2:0]]  = in_q.rx_byte;
  end

  assign reply_ack = (frame_kind_q == KIND_STATUS) ? rx_new[3] : rx_new[7];

  // One pass: next emitter byte, or the waiting input item.
  always_comb begin
    out_d        = out_q;
    out_vld_d    = out_vld_q && out_stall_i;
    em_active_d  = em_active_q;
    em_idx_d     = em_idx_q;
    em_last_d    = em_last_q;
    em_crcpos_d  = em_crcpos_q;
    em_crc_d     = em_crc_q;
    em_buf_d     = em_buf_q;
    frame_kind_d = frame_kind_q;
    rx_count_d   = rx_count_q;
    rx_frame_d   = rx_frame_q;

    if (out_free && em_active_q) begin
      out_d         = '0;
      out_d.tx_byte = em_byte;
      out_d.tx_last = (em_idx_q == em_last_q);
      out_vld_d     = 1'b1;
      em_crc_d      = crc8_byte(em_crc_q, em_byte);
      em_idx_d      = em_idx_q + 3'd1;
      em_active_d   = (em_idx_q != em_last_q);
    end else if (consume) begin
      if (in_q.opcode == OP_START) begin
        // Start a frame: send the command byte now, the rest from the emitter.
        frame_kind_d = kind;
        rx_count_d   = '0;
        rx_frame_d   = '0;
        em_buf_d     = '0;
        em_buf_d[0]  = cmd_byte;
        em_buf_d[1]  = {in_q.reg_address, 1'b0};
        if (kind == KIND_WRITE) begin
          em_buf_d[2] = in_q.write_data[31:24];
          em_buf_d[3] = in_q.write_data[23:16];
          em_buf_d[4] = in_q.write_data[15:8];
          em_buf_d[5] = in_q.write_data[7:0];
          em_crcpos_d = CRC_POS_LONG;
        end else begin
          em_crcpos_d = CRC_POS_SHORT;
        end
        // Read frames are padded to the long length like write frames.
        em_last_d     = (kind == KIND_STATUS) ? LAST_SHORT : LAST_LONG;
        em_crc_d      = crc8_byte(8'd0, cmd_byte);
        em_idx_d      = 3'd1;
        em_active_d   = 1'b1;
        out_d         = '0;
        out_d.tx_byte = cmd_byte;
        out_vld_d     = 1'b1;
      end else if (rx_count_q < rx_len) begin
        // Collect a received byte; the last one of the frame yields the reply.
        rx_frame_d = rx_new;
        rx_count_d = rx_count_q + 4'd1;
        if (rx_count_q + 4'd1 == rx_len) begin
          out_d             = '0;
          out_d.is_reply    = 1'b1;
          out_d.status_bits = {rx_new[0][2:0], rx_new[1]};
          if (frame_kind_q == KIND_READ) begin
            out_d.read_data = {rx_new[2], rx_new[3], rx_new[4], rx_new[5]};
            out_d.crc_byte  = rx_new[6];
          end else begin
            out_d.crc_byte  = rx_new[2];
          end
          out_d.ack_byte    = reply_ack;
          out_d.nack        = (reply_ack != ack_value_q);
          out_vld_d         = 1'b1;
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      em_active_q  <= 1'b0;
      em_idx_q     <= '0;
      em_last_q    <= LAST_LONG;
      em_crcpos_q  <= CRC_POS_LONG;
      em_crc_q     <= '0;
      frame_kind_q <= KIND_WRITE;
      rx_count_q   <= '0;
      rx_frame_q   <= '0;
    end else begin
      in_vld_q     <= in_vld_d;
      out_vld_q    <= out_vld_d;
      em_active_q  <= em_active_d;
      em_idx_q     <= em_idx_d;
      em_last_q    <= em_last_d;
      em_crcpos_q  <= em_crcpos_d;
      em_crc_q     <= em_crc_d;
      frame_kind_q <= frame_kind_d;
      rx_count_q   <= rx_count_d;
      rx_frame_q   <= rx_frame_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    out_q    <= out_d;
    em_buf_q <= em_buf_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // While the emitter runs, a transmit byte of its frame sits in the output register.
  a_emit_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_active_q |-> (out_vld_q && !out_q.is_reply && !out_q.tx_last))
    else $error("emitter active without a pending transmit byte");

  // Once the last byte of a frame is in the output register, the emitter is done.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_stall_i && out_q.tx_last && !out_q.is_reply) |-> !em_active_q)
    else $error("emitter still active after the last transmit byte");

  // The receive count never passes the frame length.
  a_rx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_count_q <= LEN_LONG) &&
    ((frame_kind_q != KIND_STATUS) || (rx_count_q <= LEN_SHORT)))
    else $error("receive count beyond frame length");

  // No input item is taken while the emitter is busy.
  a_no_consume_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_active_q |-> !consume)
    else $error("input item consumed during frame emission");

  // A stalled result is held.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(out_q)))
    else $error("stalled result changed");

endmodule
